### hw/rtl/cxpd_pkg.sv
// package for the chained-xor packet decoder
// holds the transfer payload types, verdict codes and register map
// no dependencies
package cxpd_pkg;

  // configuration port
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam logic [AddrWidth-1:0] AddrFixedKey = 3'd0;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_PENDING  = 2'd0,
    VERDICT_OK       = 2'd1,
    VERDICT_MISMATCH = 2'd2,
    VERDICT_EMPTY    = 2'd3
  } verdict_t;

  // one encoded byte of the packet region
  typedef struct packed {
    logic [7:0] encoded_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] packet_rand_key;
  } in_t;

  // one decoded byte
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       is_checksum;
    logic       end_of_packet;
    verdict_t   verdict;
  } out_t;

endpackage

### hw/rtl/cxpd_core.sv
// decode core: chain state registers and the one-pass unchaining logic
// depends on cxpd_pkg
module cxpd_core
  import cxpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_t        item,
  input  logic [7:0] fixed_key,
  output out_t       result
);

  logic [7:0] byte_index;
  logic [7:0] prev_encoded;
  logic [7:0] prev_intermediate;
  logic [7:0] held_rand_key;
  logic [7:0] held_checksum;
  logic [7:0] payload_sum;

  logic [7:0] idx;
  logic [7:0] pe;
  logic [7:0] pi;
  logic [7:0] rk;
  logic [7:0] mid;
  logic [7:0] plain;
  logic [7:0] payload_sum_next;
  logic [7:0] checksum_cur;

  // a start byte restarts the chain from zero with the new random key
  always_comb begin
    idx = item.first_byte ? 8'd0 : byte_index;
    pe  = item.first_byte ? 8'd0 : prev_encoded;
    pi  = item.first_byte ? 8'd0 : prev_intermediate;
    rk  = item.first_byte ? item.packet_rand_key : held_rand_key;
  end

  // outer chain with the fixed key, inner chain with the random key
  always_comb begin
    mid   = item.encoded_byte ^ (pe + fixed_key + idx + 8'd1);
    plain = mid ^ (pi + rk + idx + 8'd1);
  end

  // running payload sum and checksum compare
  always_comb begin
    payload_sum_next = item.first_byte ? 8'd0 : payload_sum + plain;
    checksum_cur     = item.first_byte ? plain : held_checksum;
    result.plain_byte    = plain;
    result.is_checksum   = item.first_byte;
    result.end_of_packet = item.last_byte;
    if (!item.last_byte) begin
      result.verdict = VERDICT_PENDING;
    end else if (item.first_byte) begin
      result.verdict = VERDICT_EMPTY;
    end else if (payload_sum_next == checksum_cur) begin
      result.verdict = VERDICT_OK;
    end else begin
      result.verdict = VERDICT_MISMATCH;
    end
  end

  // chain state advances once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index        <= 8'd0;
      prev_encoded      <= 8'd0;
      prev_intermediate <= 8'd0;
      held_rand_key     <= 8'd0;
      held_checksum     <= 8'd0;
      payload_sum       <= 8'd0;
    end else if (step) begin
      byte_index        <= idx + 8'd1;
      prev_encoded      <= item.encoded_byte;
      prev_intermediate <= mid;
      held_rand_key     <= rk;
      held_checksum     <= checksum_cur;
      payload_sum       <= payload_sum_next;
    end
  end

endmodule

### hw/rtl/chained_xor_packet_decoder.sv
// top level of the chained-xor packet decoder: handshake stages and register port
// depends on cxpd_pkg and cxpd_core
//
// Decodes a packet's encoded region (checksum byte, then payload) one byte per
// transfer and returns one decoded byte per transfer. The block takes one byte
// every cycle while the output is not stalled; each byte is decoded out of the
// input register straight into the result register, and the chain state for
// the next byte is ready in the same cycle since it needs only 8-bit adds and
// xors. The result register holds a finished byte while the input register
// already takes the next one, so a stalled output does not stall the input
// until both are full. On the last byte the verdict reports ok, mismatch or
// empty payload. fixed_key sits at byte address 0; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module chained_xor_packet_decoder
  import cxpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  logic [7:0] fixed_key;
  logic       stage_valid;
  in_t        stage_data;
  logic       advance;
  out_t       result;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == AddrFixedKey) ? {{(DataWidth-8){1'b0}}, fixed_key}
                                          : {DataWidth{1'b0}};

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_key <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr == AddrFixedKey) begin
      fixed_key <= pwdata[7:0];
    end
  end

  // stage moves into the result register when that is free or being drained
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

  // decode core
  cxpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (stage_data),
    .fixed_key (fixed_key),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // checks
  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.verdict == VERDICT_PENDING) == !out_data.end_of_packet))
    else $error("verdict does not match end_of_packet");

  a_empty_on_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_checksum && out_data.end_of_packet)
      |-> (out_data.verdict == VERDICT_EMPTY))
    else $error("start byte on last byte not flagged empty");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule
